// ===== design/pdr_pkg.sv =====
// Shared types, widths, codes and reset values of the PID damper regulator.
package pdr_pkg;

  localparam int HISTORY_DEPTH_DEF = 6;
  localparam int INTEGRAL_BITS_DEF = 32;

  localparam logic [1:0] REQ_REGULATE   = 2'd0;
  localparam logic [1:0] REQ_SET_TEMP   = 2'd1;
  localparam logic [1:0] REQ_SET_DAMPER = 2'd2;
  localparam logic [1:0] REQ_SERVO      = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_TRIGGER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPER_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPER_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_SPAN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_BIAS  = 3'd7;

  localparam int REQ_W      = 2;
  localparam int GAIN_W     = 24;
  localparam int TRIG_W     = 31;
  localparam int DMP_W      = 8;
  localparam int SPAN_W     = 9;
  localparam int BIAS_W     = 9;
  localparam int TEMP_W     = 11;
  localparam int ERR_W      = 13;
  localparam int DERIV_W    = 14;
  localparam int ANGLE_W    = 10;
  localparam int HIST_SUM_W = 13;

  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 21;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 64;
  localparam int OPND_W     = 40;
  localparam int SPLIT_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int SCALED_W   = ACC_W - FRAC_BITS;
  localparam int IVAL_LIM_LOG2 = 38;
  localparam int PID_STEPS  = 6;
  localparam int ANG_STEPS  = 2;
  localparam int STEP_W     = 3;

  localparam int NUM_W = 19;
  localparam int QUO_W = 18;
  localparam logic signed [NUM_W-1:0] ANG_HI = 19'sd511;
  localparam logic signed [NUM_W-1:0] ANG_LO = -19'sd512;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST   = 24'd327680;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST  = 24'd328;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST  = 24'd65536;
  localparam logic [TRIG_W-1:0] END_TRIGGER_RST = 31'd25000;
  localparam logic [DMP_W-1:0]  DAMPER_MIN_RST  = 8'd0;
  localparam logic [DMP_W-1:0]  DAMPER_MAX_RST  = 8'd100;
  localparam logic [SPAN_W-1:0] SERVO_SPAN_RST  = 9'd100;
  localparam logic signed [BIAS_W-1:0] SERVO_BIAS_RST = -9'sd20;
  localparam logic [TEMP_W-1:0] TARGET_TEMP_RST = 11'd275;

  typedef struct packed {
    logic vld;
    logic clr;
    logic hi;
  } mac_ctl_t;

endpackage

// ===== design/pdr_mac.sv =====
// Shared signed multiplier with product register and accumulator.
module pdr_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pdr_pkg::mac_ctl_t                      ctl_i,
  input  logic signed [pdr_pkg::MUL_A_W-1:0]     a_i,
  input  logic signed [pdr_pkg::MUL_B_W-1:0]     b_i,
  output logic signed [pdr_pkg::ACC_W-1:0]       acc_o
);
  import pdr_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     vld_q, hi_q;
  logic signed [ACC_W-1:0]  addend, acc_q;

  assign prod_d = a_i * b_i;

  always_comb begin
    addend = '0;
    if (vld_q) begin
      addend = hi_q ? (ACC_W'(prod_q) <<< SPLIT_BITS) : ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hi_q  <= 1'b0;
    end else begin
      vld_q <= ctl_i.vld;
      hi_q  <= ctl_i.hi;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= ctl_i.clr ? '0 : acc_q + addend;
  end

  assign acc_o = acc_q;

endmodule

// ===== design/pdr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module pdr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdr_pkg::QUO_W-1:0]   dividend_i,
  input  logic [pdr_pkg::DMP_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [pdr_pkg::QUO_W-1:0]   quotient_o
);
  import pdr_pkg::*;

  localparam int DCNT_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0]  quo_q;
  logic [DMP_W-1:0]  rem_q, dvs_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DMP_W:0]    shifted, trial;
  logic              fits;

  assign shifted = {rem_q, quo_q[QUO_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DMP_W-1:0] : shifted[DMP_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/pdr_hist.sv =====
// Temperature history shift line and rising-trend compare.
module pdr_hist #(
  parameter int DEPTH = pdr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [pdr_pkg::TEMP_W-1:0]   temp_i,
  output logic                         rising_o
);
  import pdr_pkg::*;

  localparam int K = (DEPTH < 3) ? DEPTH : 3;

  logic [TEMP_W-1:0]     hist_q [DEPTH];
  logic [HIST_SUM_W-1:0] newest, oldest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) hist_q[i] <= '0;
    end else if (push_i) begin
      hist_q[0] <= temp_i;
      for (int i = 1; i < DEPTH; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  always_comb begin
    newest = '0;
    oldest = '0;
    for (int i = 0; i < K; i++) begin
      newest = newest + HIST_SUM_W'(hist_q[i]);
      oldest = oldest + HIST_SUM_W'(hist_q[DEPTH-1-i]);
    end
  end

  assign rising_o = newest > oldest;

endmodule

// ===== design/pid_damper_regulator_top.sv =====
// PID damper regulator: sequencer, regulator state and configuration registers.
//
// Input channel (in_valid_i / in_stall_o) carries one request item: a
// regulation tick, a target temperature, a manual damper value or a servo
// tick. Output channel (out_valid_o / out_stall_i) returns one result item
// per request. Configuration is a write-only port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i); the user must write it only while the block is idle; the
// block itself does not enforce this. A regulation tick that runs the PID
// step sends its partial products through the shared multiplier, then goes
// through scaling and clamp before the servo angle, which every request
// computes. The servo angle passes through the serial divider (load, 18
// quotient bits, report); with damper_max at zero the divider is skipped.
// One item is in work at a time and the next is taken in the cycle after
// the result is written. in_stall_o is high from acceptance until the result
// is written to the output register; the next item is taken while that
// result waits. If the receiver stalls with a result still held, the
// finished item waits in the sequencer and the payload holds.
// Reset: gains, limits and servo settings to their defaults, target 275 F,
// auto mode, integral, error, history and positions cleared.
module pid_damper_regulator_top #(
  parameter int HISTORY_DEPTH = pdr_pkg::HISTORY_DEPTH_DEF,
  parameter int INTEGRAL_BITS = pdr_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pdr_pkg::REQ_W-1:0]           req_type_i,
  input  logic [pdr_pkg::TEMP_W-1:0]          temperature_i,
  input  logic [pdr_pkg::TEMP_W-1:0]          command_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pdr_pkg::DMP_W-1:0]           damper_target_o,
  output logic [pdr_pkg::DMP_W-1:0]           damper_position_o,
  output logic signed [pdr_pkg::ANGLE_W-1:0]  servo_angle_o,
  output logic                                mode_auto_o,
  output logic                                fire_ended_o,
  output logic                                temp_rising_o,
  output logic                                servo_moved_o
);
  import pdr_pkg::*;

  localparam int CMP_W = (INTEGRAL_BITS > TRIG_W + 1) ? INTEGRAL_BITS : TRIG_W + 1;
  localparam int EXT_W = (INTEGRAL_BITS > OPND_W) ? INTEGRAL_BITS : OPND_W;
  localparam logic signed [EXT_W-1:0] LIM_POS = EXT_W'(longint'(1) << IVAL_LIM_LOG2);
  localparam logic signed [EXT_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'((longint'(1) << FRAC_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RISE, S_PID_MAC, S_SCALE, S_CLAMP,
    S_ANG_MAC, S_DIV_GO, S_DIV, S_FIN
  } state_e;

  // configuration
  logic [GAIN_W-1:0]        gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [TRIG_W-1:0]        end_trigger_q;
  logic [DMP_W-1:0]         damper_min_q, damper_max_q;
  logic [SPAN_W-1:0]        servo_span_q;
  logic signed [BIAS_W-1:0] servo_bias_q;

  // sequencer and regulator state
  state_e                          state_q;
  logic [STEP_W-1:0]               cnt_q;
  logic [REQ_W-1:0]                req_q;
  logic [TEMP_W-1:0]               temp_q, cmd_q, target_temp_q;
  logic                            auto_q, moved_q;
  logic signed [INTEGRAL_BITS-1:0] integral_q;
  logic signed [ERR_W-1:0]         prior_err_q, err_q;
  logic signed [DERIV_W-1:0]       deriv_q;
  logic [DMP_W-1:0]                target_pos_q, servo_pos_q;
  logic signed [SCALED_W-1:0]      scaled_q;
  logic signed [ANGLE_W-1:0]       angle_q;

  // output register
  logic                      out_valid_q;
  logic [DMP_W-1:0]          out_target_q, out_pos_q;
  logic signed [ANGLE_W-1:0] out_angle_q;
  logic                      out_auto_q, out_fire_q, out_rising_q, out_moved_q;

  // datapath
  logic                            in_accept, hist_push, rising, fire_w, below_trig;
  logic signed [ERR_W-1:0]         err_w;
  logic signed [DERIV_W-1:0]       deriv_w;
  logic signed [INTEGRAL_BITS:0]   isum_w;
  logic signed [INTEGRAL_BITS-1:0] isum_sat;
  logic signed [CMP_W-1:0]         integ_cmp, trig_cmp;
  logic signed [EXT_W-1:0]         ival_ext, ival_lim;
  logic signed [OPND_W-1:0]        opnd;
  logic [GAIN_W-1:0]               gain_sel;
  mac_ctl_t                        mac_ctl;
  logic signed [MUL_A_W-1:0]       mac_a;
  logic signed [MUL_B_W-1:0]       mac_b;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         acc_rnd;
  logic signed [SCALED_W-1:0]      min_ext, max_ext, lo_w;
  logic [DMP_W-1:0]                clamp_res, cmd_clamp;
  logic [TEMP_W-1:0]               cmd_lo;
  logic signed [NUM_W-1:0]         num_w, num_mag, quo_s;
  logic                            num_neg, div_start, div_done;
  logic [QUO_W-1:0]                quotient;
  logic signed [ANGLE_W-1:0]       angle_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign hist_push  = (state_q == S_EXEC) && (req_q == REQ_REGULATE) && auto_q;

  // PID step terms
  assign err_w    = $signed({2'b00, target_temp_q}) - $signed({2'b00, temp_q});
  assign deriv_w  = DERIV_W'(err_w) - DERIV_W'(prior_err_q);
  assign isum_w   = (INTEGRAL_BITS+1)'(integral_q) + (INTEGRAL_BITS+1)'(err_w);

  always_comb begin
    isum_sat = isum_w[INTEGRAL_BITS-1:0];
    if (isum_w[INTEGRAL_BITS] != isum_w[INTEGRAL_BITS-1]) begin
      isum_sat = isum_w[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                       : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    end
  end

  assign integ_cmp  = CMP_W'(integral_q);
  assign trig_cmp   = $signed({{(CMP_W-TRIG_W){1'b0}}, end_trigger_q});
  assign below_trig = integ_cmp < trig_cmp;
  assign fire_w     = !below_trig;

  always_comb begin
    ival_ext = EXT_W'(integral_q);
    ival_lim = ival_ext;
    if (ival_ext > LIM_POS) ival_lim = LIM_POS;
    if (ival_ext < LIM_NEG) ival_lim = LIM_NEG;
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (cnt_q[STEP_W-1:1])
      2'd0: begin
        opnd     = OPND_W'(err_q);
        gain_sel = gain_prop_q;
      end
      2'd1: begin
        opnd     = ival_lim[OPND_W-1:0];
        gain_sel = gain_integ_q;
      end
      default: begin
        opnd     = OPND_W'(deriv_q);
        gain_sel = gain_deriv_q;
      end
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      S_PID_MAC: begin
        mac_ctl.vld = cnt_q < STEP_W'(PID_STEPS);
        mac_ctl.clr = cnt_q == '0;
        mac_ctl.hi  = cnt_q[0];
        mac_a       = {1'b0, gain_sel};
        mac_b       = cnt_q[0] ? {opnd[OPND_W-1], opnd[OPND_W-1:SPLIT_BITS]}
                               : {1'b0, opnd[SPLIT_BITS-1:0]};
      end
      S_ANG_MAC: begin
        mac_ctl.vld = cnt_q < STEP_W'(ANG_STEPS);
        mac_ctl.clr = cnt_q == '0;
        if (cnt_q[0]) begin
          mac_a = MUL_A_W'(servo_bias_q);
          mac_b = {{(MUL_B_W-DMP_W){1'b0}}, damper_max_q};
        end else begin
          mac_a = {{(MUL_A_W-DMP_W){1'b0}}, servo_pos_q};
          mac_b = {{(MUL_B_W-SPAN_W){1'b0}}, servo_span_q};
        end
      end
      default: ;
    endcase
  end

  pdr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // scaling toward zero and damper clamps
  assign acc_rnd = acc[ACC_W-1] ? acc + RND_ADD : acc;
  assign min_ext = $signed({{(SCALED_W-DMP_W){1'b0}}, damper_min_q});
  assign max_ext = $signed({{(SCALED_W-DMP_W){1'b0}}, damper_max_q});
  assign lo_w    = (scaled_q < min_ext) ? min_ext : scaled_q;
  assign clamp_res = (lo_w > max_ext) ? damper_max_q : lo_w[DMP_W-1:0];

  assign cmd_lo    = (cmd_q < {3'b000, damper_min_q}) ? {3'b000, damper_min_q} : cmd_q;
  assign cmd_clamp = (cmd_lo > {3'b000, damper_max_q}) ? damper_max_q : cmd_lo[DMP_W-1:0];

  // servo angle
  assign num_w     = acc[NUM_W-1:0];
  assign num_neg   = num_w[NUM_W-1];
  assign num_mag   = num_neg ? -num_w : num_w;
  assign div_start = (state_q == S_DIV_GO);
  assign quo_s     = num_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

  always_comb begin
    angle_sat = quo_s[ANGLE_W-1:0];
    if (quo_s > ANG_HI) angle_sat = ANG_HI[ANGLE_W-1:0];
    if (quo_s < ANG_LO) angle_sat = ANG_LO[ANGLE_W-1:0];
  end

  pdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag[QUO_W-1:0]),
    .divisor_i  (damper_max_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  pdr_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (hist_push),
    .temp_i   (temp_q),
    .rising_o (rising)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q   <= GAIN_PROP_RST;
      gain_integ_q  <= GAIN_INTEG_RST;
      gain_deriv_q  <= GAIN_DERIV_RST;
      end_trigger_q <= END_TRIGGER_RST;
      damper_min_q  <= DAMPER_MIN_RST;
      damper_max_q  <= DAMPER_MAX_RST;
      servo_span_q  <= SERVO_SPAN_RST;
      servo_bias_q  <= SERVO_BIAS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_PROP:   gain_prop_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_DERIV:  gain_deriv_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_END_TRIGGER: end_trigger_q <= cfg_wdata_i[TRIG_W-1:0];
        REG_DAMPER_MIN:  damper_min_q  <= cfg_wdata_i[DMP_W-1:0];
        REG_DAMPER_MAX:  damper_max_q  <= cfg_wdata_i[DMP_W-1:0];
        REG_SERVO_SPAN:  servo_span_q  <= cfg_wdata_i[SPAN_W-1:0];
        REG_SERVO_BIAS:  servo_bias_q  <= $signed(cfg_wdata_i[BIAS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      target_temp_q <= TARGET_TEMP_RST;
      auto_q        <= 1'b1;
      integral_q    <= '0;
      prior_err_q   <= '0;
      target_pos_q  <= '0;
      servo_pos_q   <= '0;
      moved_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            moved_q <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_q <= '0;
          case (req_q)
            REQ_REGULATE: begin
              if (auto_q) begin
                if (below_trig) begin
                  integral_q  <= isum_sat;
                  prior_err_q <= err_w;
                  state_q     <= S_PID_MAC;
                end else begin
                  state_q <= S_RISE;
                end
              end else begin
                state_q <= S_ANG_MAC;
              end
            end
            REQ_SET_TEMP: begin
              target_temp_q <= cmd_q;
              auto_q        <= 1'b1;
              state_q       <= S_ANG_MAC;
            end
            REQ_SET_DAMPER: begin
              integral_q   <= '0;
              target_pos_q <= cmd_clamp;
              auto_q       <= 1'b0;
              state_q      <= S_ANG_MAC;
            end
            REQ_SERVO: begin
              state_q <= S_ANG_MAC;
              if (target_pos_q > servo_pos_q) begin
                servo_pos_q <= servo_pos_q + 1'b1;
                moved_q     <= 1'b1;
              end else if (target_pos_q < servo_pos_q) begin
                servo_pos_q <= servo_pos_q - 1'b1;
                moved_q     <= 1'b1;
              end
            end
            default: state_q <= S_ANG_MAC;
          endcase
        end
        S_RISE: begin
          if (rising) integral_q <= '0;
          state_q <= S_ANG_MAC;
        end
        S_PID_MAC: begin
          if (cnt_q == STEP_W'(PID_STEPS)) begin
            state_q <= S_SCALE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SCALE: state_q <= S_CLAMP;
        S_CLAMP: begin
          target_pos_q <= clamp_res;
          cnt_q        <= '0;
          state_q      <= S_ANG_MAC;
        end
        S_ANG_MAC: begin
          if (cnt_q == STEP_W'(ANG_STEPS)) begin
            state_q <= (damper_max_q == '0) ? S_FIN : S_DIV_GO;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV_GO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= req_type_i;
      temp_q <= temperature_i;
      cmd_q  <= command_value_i;
    end
    if (state_q == S_EXEC) begin
      err_q   <= err_w;
      deriv_q <= deriv_w;
    end
    if (state_q == S_SCALE) scaled_q <= acc_rnd[ACC_W-1:FRAC_BITS];
    if (state_q == S_ANG_MAC && cnt_q == STEP_W'(ANG_STEPS)) angle_q <= ANGLE_W'(servo_bias_q);
    if (state_q == S_DIV && div_done) angle_q <= angle_sat;
    if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
      out_target_q <= target_pos_q;
      out_pos_q    <= servo_pos_q;
      out_angle_q  <= angle_q;
      out_auto_q   <= auto_q;
      out_fire_q   <= fire_w;
      out_rising_q <= rising;
      out_moved_q  <= moved_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign damper_target_o   = out_target_q;
  assign damper_position_o = out_pos_q;
  assign servo_angle_o     = out_angle_q;
  assign mode_auto_o       = out_auto_q;
  assign fire_ended_o      = out_fire_q;
  assign temp_rising_o     = out_rising_q;
  assign servo_moved_o     = out_moved_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("sequencer took an item but did not go busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result item raised outside the finish step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished while the sequencer was not waiting on it");

endmodule
